// ----- src/de_bruijn_sequence_generator_core_defines.svh -----
// Assertion macros for the de Bruijn generator datapath RTL.
`ifndef DE_BRUIJN_SEQUENCE_GENERATOR_CORE_DEFINES_SVH
`define DE_BRUIJN_SEQUENCE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DBSG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DBSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dbsg_pkg.sv -----
// Types and constants shared by the de Bruijn generator modules.
package dbsg_pkg;

  localparam int unsigned ORDER_W = 4;
  localparam int unsigned EDGE_W  = 2;
  localparam int unsigned EPOCH_W = 4;
  localparam int unsigned DATA_W  = 8;

  localparam logic [EDGE_W-1:0]  EDGES_FULL  = 2'd2;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd2;
  localparam logic [ORDER_W-1:0] ORDER_ONE   = 4'd1;

  typedef enum logic [1:0] {
    PH_TOUR  = 2'd0,
    PH_TAIL  = 2'd1,
    PH_DONE  = 2'd2,
    PH_SHORT = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_LOOKUP = 3'd2,
    ST_DECIDE = 3'd3,
    ST_REFILL = 3'd4
  } state_e;

  typedef struct packed {
    logic begin_seq;
    logic bump_epoch;
    logic load_order;
    logic clr_step;
    logic emit_short;
    logic decide;
    logic refill;
  } cmd_t;

  typedef struct packed {
    logic phase_tour;
    logic phase_done;
    logic can_push;
    logic pop_last;
    logic out_free;
    logic clr_done;
    logic epoch_full;
  } sts_t;

endpackage

// ----- src/de_bruijn_sequence_generator_core.sv -----
// Binary de Bruijn sequence generator, one bit per request word.
// Usage:
//   s_axis: request words. tdata[0] = restart (1 starts over at the first bit,
//     0 asks for the next bit). A request after the final bit starts over too.
//   m_axis: one result word per request. tdata[0] = sequence bit, tlast marks
//     the final bit of the sequence.
//   cfg: write of order_n (4 bits, 0 acts as 1, values above MAX_ORDER saturate);
//     a write restarts the sequence. Write only while no request is in flight.
// Timing: a tail bit or an order-1 bit goes from the lookup state straight into
//   the output register. In the tour each node push takes a lookup state (edge
//   count read) then a decide state (update), the pop takes the same pair, and
//   unless the stack is then empty a refill state reads the new top from the
//   stack; the edge-count memory read port sets this pace. A new request is
//   taken only once the block is back in the idle state.
// Reset and restarts: edge counts carry an epoch tag, so a restart is free,
//   except after reset and every 16th restart or order write, when a clearing
//   pass over every edge-count entry runs before the next request is served;
//   config writes are still taken during that pass.
// Stall: a finished word waits in the output register; the next request is
//   accepted meanwhile, its pushes go on and its pop holds until that drains.
module de_bruijn_sequence_generator_core
  import dbsg_pkg::*;
#(
  parameter int unsigned MAX_ORDER = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DATA_W-1:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DATA_W-1:0]  m_axis_tdata,   // [0] seq_bit, [7:1] zero
  output logic               m_axis_tlast,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ORDER_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic out_bit;

  dbsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .restart_i  (s_axis_tdata[0]),
    .in_ready_o (s_axis_tready),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dbsg_datapath #(
    .MAX_ORDER(MAX_ORDER)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_data_i (cfg_data_i),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_bit_o  (out_bit),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {{(DATA_W-1){1'b0}}, out_bit};

endmodule

// ----- src/dbsg_ctrl.sv -----
// Sequencer for the de Bruijn generator: clearing pass, request handling, tour steps.
module dbsg_ctrl
  import dbsg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic restart_i,
  output logic in_ready_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cfg_ready_o    = 1'b1;
        cmd_o.clr_step = 1'b1;
        if (cfg_valid_i) begin
          cmd_o.begin_seq  = 1'b1;
          cmd_o.load_order = 1'b1;
        end
        if (sts_i.clr_done) begin
          state_d = pend_q ? ST_LOOKUP : ST_IDLE;
          pend_d  = 1'b0;
        end
      end
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.begin_seq  = 1'b1;
          cmd_o.load_order = 1'b1;
          cmd_o.bump_epoch = 1'b1;
          if (sts_i.epoch_full) state_d = ST_CLEAR;
        end else if (in_valid_i) begin
          if (restart_i || sts_i.phase_done) begin
            cmd_o.begin_seq  = 1'b1;
            cmd_o.bump_epoch = 1'b1;
            // epoch tags run out: sweep the edge counts before serving the word
            if (sts_i.epoch_full) begin
              state_d = ST_CLEAR;
              pend_d  = 1'b1;
            end else begin
              state_d = ST_LOOKUP;
            end
          end else begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (!sts_i.phase_tour) begin
          if (sts_i.out_free) begin
            cmd_o.emit_short = 1'b1;
            state_d          = ST_IDLE;
          end
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.can_push) begin
          state_d = ST_LOOKUP;
        end else if (sts_i.out_free) begin
          state_d = sts_i.pop_last ? ST_IDLE : ST_REFILL;
        end
      end
      ST_REFILL: begin
        cmd_o.refill = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

// ----- src/dbsg_datapath.sv -----
// Datapath of the de Bruijn generator: edge counts, node stack, tail counter, output word.
`include "de_bruijn_sequence_generator_core_defines.svh"

module dbsg_datapath
  import dbsg_pkg::*;
#(
  parameter int unsigned MAX_ORDER = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [ORDER_W-1:0] cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               out_bit_o,
  output logic               out_last_o
);

  localparam int unsigned NODE_W      = MAX_ORDER - 1;
  localparam int unsigned NODE_DEPTH  = 2 ** NODE_W;
  localparam int unsigned STACK_DEPTH = 2 ** MAX_ORDER + 1;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH);
  localparam int unsigned WORD_W      = EPOCH_W + EDGE_W;

  function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] o);
    logic [ORDER_W-1:0] r;
    if (o == '0) begin
      r = ORDER_ONE;
    end else if (int'(o) > int'(MAX_ORDER)) begin
      r = ORDER_W'(MAX_ORDER);
    end else begin
      r = o;
    end
    return r;
  endfunction

  logic [WORD_W-1:0] edge_mem [NODE_DEPTH];
  logic [NODE_W-1:0] stack_mem [STACK_DEPTH];

  logic [ORDER_W-1:0] order_q, order_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [NODE_W-1:0]  top_q, top_d;
  logic [ORDER_W-1:0] tail_q, tail_d;
  phase_e             phase_q, phase_d;
  logic [NODE_W-1:0]  clr_idx_q, clr_idx_d;
  logic               out_valid_q, out_valid_d;
  logic               out_bit_q, out_bit_d;
  logic               out_last_q, out_last_d;

  logic [WORD_W-1:0]  edge_rd_q;
  logic [NODE_W-1:0]  stack_rd_q;
  logic [CNT_W-1:0]   stk_raddr;

  logic [ORDER_W-1:0] n_eff;
  logic [ORDER_W-1:0] begin_order;
  logic [NODE_W-1:0]  node_mask;
  logic [EDGE_W-1:0]  ecnt;
  logic [NODE_W-1:0]  nxt;
  logic               can_push;
  logic               out_free;
  logic               do_emit;
  logic               emit_bit;
  logic               emit_last;
  logic [ORDER_W:0]   tail_inc;
  logic [ORDER_W:0]   tail_lim;

  logic               ew_en;
  logic [NODE_W-1:0]  ew_addr;
  logic [WORD_W-1:0]  ew_data;
  logic               sw_en;

  assign n_eff       = eff_order(order_q);
  assign begin_order = cmd_i.load_order ? cfg_data_i : order_q;
  assign node_mask   = (NODE_W'(1) << (n_eff - ORDER_ONE)) - NODE_W'(1);
  // a stale epoch tag means the entry still holds its fresh count
  assign ecnt        = (edge_rd_q[EDGE_W +: EPOCH_W] == epoch_q) ?
                       edge_rd_q[EDGE_W-1:0] : EDGES_FULL;
  assign nxt         = ((top_q << 1) | NODE_W'(ecnt == EDGES_FULL)) & node_mask;
  assign can_push    = (ecnt != '0) && (count_q != CNT_W'(STACK_DEPTH));
  assign out_free    = !out_valid_q || out_ready_i;
  assign stk_raddr   = (count_q >= CNT_W'(2)) ? (count_q - CNT_W'(2)) : '0;
  assign tail_inc    = {1'b0, tail_q} + (ORDER_W+1)'(1);
  assign tail_lim    = {1'b0, n_eff} - (ORDER_W+1)'(2);

  always_comb begin
    order_d     = order_q;
    epoch_d     = epoch_q;
    count_d     = count_q;
    top_d       = top_q;
    tail_d      = tail_q;
    phase_d     = phase_q;
    clr_idx_d   = clr_idx_q;
    out_valid_d = out_valid_q;
    out_bit_d   = out_bit_q;
    out_last_d  = out_last_q;
    do_emit     = 1'b0;
    emit_bit    = 1'b0;
    emit_last   = 1'b0;
    ew_en       = 1'b0;
    ew_addr     = top_q;
    ew_data     = {epoch_q, ecnt - EDGE_W'(1)};
    sw_en       = 1'b0;

    if (cmd_i.begin_seq) begin
      order_d = begin_order;
      count_d = CNT_W'(1);
      top_d   = '0;
      tail_d  = '0;
      phase_d = (eff_order(begin_order) == ORDER_ONE) ? PH_SHORT : PH_TOUR;
      if (cmd_i.bump_epoch) epoch_d = epoch_q + EPOCH_W'(1);
    end

    if (cmd_i.clr_step) begin
      ew_en     = 1'b1;
      ew_addr   = clr_idx_q;
      ew_data   = {epoch_q, EDGES_FULL};
      clr_idx_d = clr_idx_q + NODE_W'(1);
    end

    if (cmd_i.emit_short) begin
      do_emit = 1'b1;
      unique case (phase_q)
        PH_SHORT: begin
          if (tail_q == '0) begin
            tail_d = ORDER_ONE;
          end else begin
            emit_bit  = 1'b1;
            emit_last = 1'b1;
            phase_d   = PH_DONE;
          end
        end
        PH_TAIL: begin
          tail_d = tail_inc[ORDER_W-1:0];
          if (tail_inc >= tail_lim) begin
            emit_last = 1'b1;
            phase_d   = PH_DONE;
          end
        end
        default: emit_last = 1'b1;
      endcase
    end

    if (cmd_i.decide) begin
      if (can_push) begin
        // use one edge of the top node and push its target
        ew_en   = 1'b1;
        sw_en   = 1'b1;
        count_d = count_q + CNT_W'(1);
        top_d   = nxt;
      end else if (out_free) begin
        // pop: the popped node's low bit is the next word
        do_emit  = 1'b1;
        emit_bit = top_q[0];
        count_d  = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          tail_d = '0;
          if (n_eff <= ORDER_RESET) begin
            emit_last = 1'b1;
            phase_d   = PH_DONE;
          end else begin
            phase_d = PH_TAIL;
          end
        end
      end
    end

    // the bottom entry is always node zero and lives in no memory word
    if (cmd_i.refill) top_d = (count_q == CNT_W'(1)) ? '0 : stack_rd_q;

    if (do_emit) begin
      out_valid_d = 1'b1;
      out_bit_d   = emit_bit;
      out_last_d  = emit_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= ORDER_RESET;
      epoch_q     <= '0;
      count_q     <= CNT_W'(1);
      top_q       <= '0;
      tail_q      <= '0;
      phase_q     <= PH_TOUR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      order_q     <= order_d;
      epoch_q     <= epoch_d;
      count_q     <= count_d;
      top_q       <= top_d;
      tail_q      <= tail_d;
      phase_q     <= phase_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bit_q  <= out_bit_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (ew_en) edge_mem[ew_addr] <= ew_data;
    edge_rd_q <= edge_mem[top_q];
  end

  always_ff @(posedge clk_i) begin
    if (sw_en) stack_mem[count_q] <= nxt;
    stack_rd_q <= stack_mem[stk_raddr];
  end

  assign sts_o.phase_tour = (phase_q == PH_TOUR);
  assign sts_o.phase_done = (phase_q == PH_DONE);
  assign sts_o.can_push   = can_push;
  assign sts_o.pop_last   = (count_q == CNT_W'(1));
  assign sts_o.out_free   = out_free;
  assign sts_o.clr_done   = &clr_idx_q;
  assign sts_o.epoch_full = &epoch_q;

  assign out_valid_o = out_valid_q;
  assign out_bit_o   = out_bit_q;
  assign out_last_o  = out_last_q;

  `DBSG_ASSERT_IMPL(a_emit_room, do_emit, out_free, "word emitted into a full output register")
  `DBSG_ASSERT_IMPL(a_tail_empty, phase_q == PH_TAIL, count_q == '0, "tail phase with nodes on stack")
  `DBSG_ASSERT_IMPL(a_tour_nonempty, cmd_i.decide, count_q != '0, "tour step on an empty stack")
  `DBSG_ASSERT_IMPL(a_one_writer, cmd_i.clr_step, !cmd_i.decide, "clearing pass overlaps a tour step")
  `DBSG_ASSERT_NEXT(a_begin_state, cmd_i.begin_seq, count_q == CNT_W'(1) && top_q == '0, "restart left stack dirty")

endmodule

// ----- sim/dbsg_result_checker.sv -----
// Result checker for the de Bruijn generator: predicts every requested bit and compares it.
module dbsg_result_checker
  import dbsg_pkg::*;
#(
  parameter int unsigned MAX_ORDER = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_ready_i,
  input  logic [DATA_W-1:0]  req_data_i,   // [0] restart, [7:1] zero
  input  logic               bit_valid_i,
  input  logic               bit_ready_i,
  input  logic [DATA_W-1:0]  bit_data_i,   // [0] seq_bit, [7:1] zero
  input  logic               bit_last_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [ORDER_W-1:0] cfg_data_i,
  output int unsigned        mismatch_cnt_o,
  output int unsigned        bits_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODES     = 1 << (MAX_ORDER - 1);
  localparam int unsigned STACK_LEN = (1 << MAX_ORDER) + 1;

  typedef struct packed {
    logic seq_bit;
    logic last_bit;
  } seq_word_t;

  logic [ORDER_W-1:0]   order_q;
  logic [EDGE_W-1:0]    edges_left [NODES];
  logic [MAX_ORDER-2:0] node_stack [STACK_LEN];
  int unsigned          depth;
  int unsigned          tail_zeros;
  phase_e               walk_phase;
  int unsigned          mismatches;
  seq_word_t            due_bits [$];

  function automatic int unsigned eff_order();
    if (order_q == '0) return 1;
    if (order_q > MAX_ORDER) return MAX_ORDER;
    return order_q;
  endfunction

  function automatic void restart_walk();
    for (int i = 0; i < NODES; i++) edges_left[i] = EDGES_FULL;
    node_stack[0] = '0;
    depth = 1;
    tail_zeros = 0;
    walk_phase = (eff_order() == 1) ? PH_SHORT : PH_TOUR;
  endfunction

  function automatic seq_word_t next_debruijn_bit(logic restart);
    int unsigned n;
    int unsigned mask;
    int unsigned top;
    seq_word_t w;
    if (restart || walk_phase == PH_DONE) restart_walk();
    n = eff_order();
    mask = (1 << (n - 1)) - 1;
    w = '0;
    case (walk_phase)
      PH_SHORT: begin
        if (tail_zeros == 0) begin
          tail_zeros = 1;
        end else begin
          w.seq_bit = 1'b1;
          w.last_bit = 1'b1;
          walk_phase = PH_DONE;
        end
      end
      PH_TAIL: begin
        tail_zeros++;
        if (tail_zeros >= n - 2) begin
          w.last_bit = 1'b1;
          walk_phase = PH_DONE;
        end
      end
      default: begin
        // push while the top node has an unused edge, emit its low bit on pop
        forever begin
          if (depth == 0 || depth > STACK_LEN) begin
            w.last_bit = 1'b1;
            walk_phase = PH_DONE;
            return w;
          end
          top = node_stack[depth - 1] & mask;
          if (edges_left[top] != 0 && depth < STACK_LEN) begin
            node_stack[depth] = (MAX_ORDER-1)'(((top << 1) |
                                (edges_left[top] == EDGES_FULL)) & mask);
            edges_left[top]--;
            depth++;
          end else begin
            depth--;
            w.seq_bit = top[0];
            if (depth == 0) begin
              if (n <= 2) begin
                w.last_bit = 1'b1;
                walk_phase = PH_DONE;
              end else begin
                walk_phase = PH_TAIL;
                tail_zeros = 0;
              end
            end
            return w;
          end
        end
      end
    endcase
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    seq_word_t want;
    if (!rst_ni) begin
      order_q = ORDER_RESET;
      restart_walk();
      due_bits.delete();
      mismatches = 0;
      mismatch_cnt_o <= 0;
      bits_due_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        order_q = cfg_data_i;
        restart_walk();
      end
      // results always belong to earlier requests: retire before adding
      if (bit_valid_i && bit_ready_i) begin
        if (due_bits.size() == 0) begin
          $error("result word with no request waiting: seq_bit=%0b last_bit=%0b",
                 bit_data_i[0], bit_last_i);
          mismatches++;
        end else begin
          want = due_bits.pop_front();
          if (bit_data_i[0] !== want.seq_bit) begin
            $error("seq_bit: expected %0b, got %0b", want.seq_bit, bit_data_i[0]);
            mismatches++;
          end
          if (bit_last_i !== want.last_bit) begin
            $error("last_bit: expected %0b, got %0b", want.last_bit, bit_last_i);
            mismatches++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        due_bits.insert(due_bits.size(), next_debruijn_bit(req_data_i[0]));
      end
      mismatch_cnt_o <= mismatches;
      bits_due_o <= due_bits.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the de Bruijn generator: clock, reset, request and order stimulus, verdict.
module tb_top
  import dbsg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ORDER      = 12;
  localparam int unsigned CYCLE_LIMIT    = 2_000_000;
  localparam int unsigned DRAIN_LIMIT    = 100_000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned PRESSURE_PHASE = 2;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned NUM_PHASES     = 16;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [DATA_W-1:0]  m_axis_tdata;
  logic               m_axis_tlast;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [ORDER_W-1:0] cfg_data_i;

  int unsigned req_idle_pct;
  int unsigned stall_pct;
  int unsigned phase_no;
  int unsigned mismatch_cnt;
  int unsigned bits_due;

  // small orders dominate; 12 and up all run the full-size tour
  logic [ORDER_W-1:0] phase_orders [NUM_PHASES] =
    '{4'd3, 4'd12, 4'd1, 4'd5, 4'd0, 4'd15, 4'd2, 4'd7,
      4'd4, 4'd13, 4'd6, 4'd10, 4'd8, 4'd11, 4'd9, 4'd14};

  de_bruijn_sequence_generator_core #(
    .MAX_ORDER(MAX_ORDER)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  dbsg_result_checker #(
    .MAX_ORDER(MAX_ORDER)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .bit_valid_i   (m_axis_tvalid),
    .bit_ready_i   (m_axis_tready),
    .bit_data_i    (m_axis_tdata),
    .bit_last_i    (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .mismatch_cnt_o(mismatch_cnt),
    .bits_due_o    (bits_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls, plus one long hold-off to back the block up
  initial begin : result_sink
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase_no == PRESSURE_PHASE && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_request(input logic restart);
    while ($urandom_range(99) < req_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(DATA_W-1){1'b0}}, restart};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (bits_due != 0);
  endtask

  // order writes happen only with no request in flight
  task automatic write_order(input logic [ORDER_W-1:0] order);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= order;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_traffic(input int unsigned mode);
    case (mode)
      1:       begin req_idle_pct <= 85; stall_pct <= 0;  end
      2:       begin req_idle_pct <= 0;  stall_pct <= 85; end
      3:       begin req_idle_pct <= 24; stall_pct <= 24; end
      default: begin req_idle_pct <= 0;  stall_pct <= 0;  end
    endcase
  endtask

  initial begin : stimulus
    int unsigned count;
    int unsigned guard;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    req_idle_pct = 0;
    stall_pct = 0;
    phase_no = NUM_PHASES + 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset order: run past the final bit, then restart mid-sequence
    repeat (6) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    // order one, including the request after its last bit
    write_order(ORDER_ONE);
    repeat (3) send_request(1'b0);
    // order zero acts as order one
    write_order(4'd0);
    repeat (2) send_request(1'b0);
    // orders above the maximum saturate
    write_order(4'd15);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    write_order(4'd13);
    send_request(1'b0);

    for (int k = 0; k < NUM_PHASES; k++) begin
      write_order(phase_orders[k]);
      set_traffic((k == PRESSURE_PHASE) ? 0 : k % 4);
      phase_no <= k;
      count = (phase_orders[k] >= 10) ? 40 : 125;
      for (int j = 0; j < count; j++) send_request($urandom_range(39) == 0);
    end

    s_axis_tvalid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (bits_due != 0 && guard < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && bits_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
